[hw/rtl/life_stencil_step_top_assert.svh]
// ----------------------------------------------------------------------------
// life stencil step assertion macros
// shared property wrappers for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef LIFE_STENCIL_STEP_TOP_ASSERT_SVH
`define LIFE_STENCIL_STEP_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define LSST_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsst check failed");

// next-cycle implication, off during reset
`define LSST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsst check failed");

`endif

[hw/rtl/lsst_pkg.sv]
// ----------------------------------------------------------------------------
// lsst_pkg
// types, constants and helpers shared by the life stencil step block
// ----------------------------------------------------------------------------
package lsst_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SIZE_W      = 11;
  localparam int FLUSH_W     = $clog2(MAX_WIDTH + 2);
  localparam int MIN_SIZE    = 3;
  localparam int RESET_WIDTH  = 800;
  localparam int RESET_HEIGHT = 600;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // window bit layout: three columns of three, oldest column in bits 2:0,
  // top row at bit 0 of each column
  localparam logic [8:0] COL_LEFT   = 9'h007;
  localparam logic [8:0] COL_RIGHT  = 9'h1c0;
  localparam logic [8:0] ROW_TOP    = 9'h049;
  localparam logic [8:0] ROW_BOTTOM = 9'h124;
  localparam int         CENTRE_BIT = 4;

  typedef struct packed {
    logic [COL_W-1:0] ic;
    logic             v;
    logic             use_shift;
    logic             emit;
    logic             edge_left;
    logic             edge_right;
    logic             edge_top;
    logic             edge_bottom;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } lsst_item_t;

  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } lsst_queue_status_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(MIN_SIZE)) begin
      r = SIZE_W'(MIN_SIZE);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // B3/S23 on a masked window
  function automatic logic next_state(logic [8:0] win);
    logic [3:0] count;
    count = '0;
    for (int b = 0; b < 9; b++) begin
      if (b != CENTRE_BIT) begin
        count = count + {3'b000, win[b]};
      end
    end
    return (count == 4'd3) || ((count == 4'd2) && win[CENTRE_BIT]);
  endfunction

endpackage

[hw/rtl/lsst_if.sv]
// ----------------------------------------------------------------------------
// lsst channel interfaces
// valid/ready channels for cells in and results out
// ----------------------------------------------------------------------------
interface lsst_in_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic pad;

  modport source (output valid, output cell_alive, output pad, input ready);
  modport sink   (input valid, input cell_alive, input pad, output ready);
endinterface

interface lsst_out_if import lsst_pkg::*; ;
  logic             valid;
  logic             ready;
  logic             next_alive;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             last_of_frame;

  modport source (output valid, output next_alive, output out_col, output out_row,
                  output last_of_frame, input ready);
  modport sink   (input valid, input next_alive, input out_col, input out_row,
                  input last_of_frame, output ready);
endinterface

[hw/rtl/life_stencil_step_top.sv]
// ----------------------------------------------------------------------------
// life_stencil_step_top
// a result passes the queue, the line memory read and the output register after
// the item completing its window is taken (one row and one cell behind input)
// throughput one item per cycle unless the queue is full; one line read, one write
// reset: control cleared, sizes 800 x 600; line memory is not swept, rows are
// rebuilt each frame and edge masking hides what was there before
// ----------------------------------------------------------------------------
`include "life_stencil_step_top_assert.svh"

module life_stencil_step_top import lsst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  lsst_in_if.sink               cell_in,
  lsst_out_if.source            result_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [SIZE_W-1:0]  frame_width;
  logic [SIZE_W-1:0]  frame_height;
  logic [SIZE_W-1:0]  width_eff;
  logic [SIZE_W-1:0]  height_eff;
  logic               cfg_write;
  reg_index_t         cfg_sel;

  lsst_queue_status_t q_status;
  logic               push;
  lsst_item_t         push_item;
  logic               pop;
  logic               q_valid;
  lsst_item_t         q_item;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= SIZE_W'(RESET_WIDTH);
      frame_height <= SIZE_W'(RESET_HEIGHT);
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  assign width_eff  = clamp_size(frame_width, SIZE_W'(MAX_WIDTH));
  assign height_eff = clamp_size(frame_height, SIZE_W'(MAX_HEIGHT));

  lsst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cell_in   (cell_in),
    .width     (width_eff),
    .height    (height_eff),
    .restart   (cfg_write),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  lsst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .status    (q_status)
  );

  lsst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .result_out (result_out)
  );

  `LSST_ASSERT_IMP(a_full_stalls_input, clk, rst, q_status.full, !cell_in.ready)
  `LSST_ASSERT_IMP(a_queue_bound, clk, rst, 1'b1, q_status.count <= QCNT_W'(QUEUE_DEPTH))
  `LSST_ASSERT_NEXT(a_cell_queued, clk, rst,
                    cell_in.valid && cell_in.ready && !cell_in.pad,
                    q_status.count != '0)
  `LSST_ASSERT_IMP(a_last_not_origin, clk, rst,
                   result_out.valid && result_out.last_of_frame,
                   (result_out.out_col != '0) && (result_out.out_row != '0))

endmodule

[hw/rtl/lsst_ram.sv]
// ----------------------------------------------------------------------------
// lsst_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lsst_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/lsst_queue.sv]
// ----------------------------------------------------------------------------
// lsst_queue
// short fifo of classified cell records between the front and back parts
// ----------------------------------------------------------------------------
module lsst_queue import lsst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lsst_item_t         push_item,
  input  logic               pop,
  output logic               pop_valid,
  output lsst_item_t         pop_item,
  output lsst_queue_status_t status
);

  lsst_item_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign pop_valid    = count != '0;
  assign pop_item     = slots[rd_ptr];
  assign status.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign status.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/lsst_front.sv]
// ----------------------------------------------------------------------------
// lsst_front
// takes cells in raster order, tracks input and result positions and flush
// ----------------------------------------------------------------------------
module lsst_front import lsst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  lsst_in_if.sink            cell_in,
  input  logic [SIZE_W-1:0]  width,
  input  logic [SIZE_W-1:0]  height,
  input  logic               restart,
  input  lsst_queue_status_t q_status,
  output logic               push,
  output lsst_item_t         push_item
);

  logic [COL_W-1:0]   in_col, in_col_next;
  logic [ROW_W-1:0]   in_row, in_row_next;
  logic [COL_W-1:0]   emit_col, emit_col_next;
  logic [ROW_W-1:0]   emit_row, emit_row_next;
  logic [FLUSH_W-1:0] flush_left, flush_left_next;

  logic flushing;
  logic col_end;
  logic row_end;
  logic ecol_end;
  logic erow_end;
  logic emit;
  logic take;

  assign flushing = flush_left != '0;
  assign col_end  = (SIZE_W'(in_col) + SIZE_W'(1)) >= width;
  assign row_end  = (SIZE_W'(in_row) + SIZE_W'(1)) >= height;
  assign ecol_end = (SIZE_W'(emit_col) + SIZE_W'(1)) >= width;
  assign erow_end = (SIZE_W'(emit_row) + SIZE_W'(1)) >= height;
  assign emit     = flushing || (in_row >= ROW_W'(2)) ||
                    ((in_row == ROW_W'(1)) && (in_col != '0));

  assign cell_in.ready = !q_status.full;
  // a pad outside a flush is taken and dropped
  assign take = cell_in.valid && cell_in.ready && (flushing || !cell_in.pad);
  assign push = take;

  always_comb begin
    push_item.ic          = in_col;
    push_item.v           = flushing ? 1'b0 : cell_in.cell_alive;
    push_item.use_shift   = in_col == '0;
    push_item.emit        = emit;
    push_item.edge_left   = emit_col == '0;
    push_item.edge_right  = ecol_end;
    push_item.edge_top    = emit_row == '0;
    push_item.edge_bottom = erow_end;
    push_item.col         = emit_col;
    push_item.row         = emit_row;
  end

  always_comb begin
    in_col_next     = in_col;
    in_row_next     = in_row;
    emit_col_next   = emit_col;
    emit_row_next   = emit_row;
    flush_left_next = flush_left;
    if (restart) begin
      in_col_next     = '0;
      in_row_next     = '0;
      emit_col_next   = '0;
      emit_row_next   = '0;
      flush_left_next = '0;
    end else if (take) begin
      in_col_next = col_end ? '0 : in_col + COL_W'(1);
      if (!flushing) begin
        if (col_end) begin
          if (row_end) begin
            in_row_next     = '0;
            flush_left_next = FLUSH_W'(width) + FLUSH_W'(1);
          end else begin
            in_row_next = in_row + ROW_W'(1);
          end
        end
      end else begin
        flush_left_next = flush_left - FLUSH_W'(1);
      end
      if (emit) begin
        if (ecol_end) begin
          emit_col_next = '0;
          emit_row_next = erow_end ? '0 : emit_row + ROW_W'(1);
        end else begin
          emit_col_next = emit_col + COL_W'(1);
        end
      end
      // end of flush starts a new frame
      if (flushing && (flush_left == FLUSH_W'(1))) begin
        in_col_next   = '0;
        in_row_next   = '0;
        emit_col_next = '0;
        emit_row_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col     <= '0;
      in_row     <= '0;
      emit_col   <= '0;
      emit_row   <= '0;
      flush_left <= '0;
    end else begin
      in_col     <= in_col_next;
      in_row     <= in_row_next;
      emit_col   <= emit_col_next;
      emit_row   <= emit_row_next;
      flush_left <= flush_left_next;
    end
  end

endmodule

[hw/rtl/lsst_back.sv]
// ----------------------------------------------------------------------------
// lsst_back
// line store read and update, window shift, rule evaluation, output register
// ----------------------------------------------------------------------------
module lsst_back import lsst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  lsst_item_t q_item,
  output logic       pop,
  lsst_out_if.source result_out
);

  logic             s1_valid;
  lsst_item_t       s1_item;
  logic [8:0]       window;
  logic [8:0]       window_next;
  logic [8:0]       eval_win;
  logic [2:0]       column;
  logic [1:0]       rd_lines;
  logic             proc;

  logic             out_valid;
  logic             out_alive;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic             out_last;

  // line word: bit 1 row two above, bit 0 row one above
  lsst_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (proc),
    .wr_addr (s1_item.ic),
    .wr_data ({rd_lines[0], s1_item.v}),
    .rd_en   (pop),
    .rd_addr (q_item.ic),
    .rd_data (rd_lines)
  );

  assign proc = s1_valid && (!s1_item.emit || !out_valid || result_out.ready);
  assign pop  = q_valid && (!s1_valid || proc);

  assign column      = {s1_item.v, rd_lines[0], rd_lines[1]};
  assign window_next = {column, window[8:3]};

  always_comb begin
    // first column of a row finishes the previous row's last cell
    eval_win = s1_item.use_shift ? {3'b000, window[8:3]} : window_next;
    if (s1_item.edge_left) begin
      eval_win = eval_win & ~COL_LEFT;
    end
    if (s1_item.edge_right) begin
      eval_win = eval_win & ~COL_RIGHT;
    end
    if (s1_item.edge_top) begin
      eval_win = eval_win & ~ROW_TOP;
    end
    if (s1_item.edge_bottom) begin
      eval_win = eval_win & ~ROW_BOTTOM;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item <= q_item;
    end
    if (proc && s1_item.emit) begin
      out_alive <= next_state(eval_win);
      out_col   <= s1_item.col;
      out_row   <= s1_item.row;
      out_last  <= s1_item.edge_right && s1_item.edge_bottom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      window    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (proc) begin
        s1_valid <= 1'b0;
      end
      if (proc) begin
        window <= window_next;
      end
      if (proc && s1_item.emit) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.next_alive    = out_alive;
  assign result_out.out_col       = out_col;
  assign result_out.out_row       = out_row;
  assign result_out.last_of_frame = out_last;

endmodule
